// ===== hdl/itrd_pkg.sv =====
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared constants, types and digit encoding for the radix digit converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

   localparam int VALUE_BITS = 31;
   localparam int BASE_BITS  = 6;
   localparam int CHAR_BITS  = 7;
   localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
   localparam int IDX_BITS   = $clog2(VALUE_BITS);

   localparam logic [BASE_BITS-1:0] BASE_MIN   = BASE_BITS'(2);
   localparam logic [BASE_BITS-1:0] BASE_MAX   = BASE_BITS'(36);
   localparam logic [BASE_BITS-1:0] BASE_RESET = BASE_BITS'(10);
   localparam logic [BASE_BITS-1:0] NINE       = BASE_BITS'(9);
   localparam logic [BASE_BITS-1:0] TEN        = BASE_BITS'(10);
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = CHAR_BITS'(48);
   localparam logic [CHAR_BITS-1:0] CHAR_A     = CHAR_BITS'(65);

   typedef struct packed {
      logic start;
      logic use_input;
   } div_ctl_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic                  quotient_zero;
      logic [BASE_BITS-1:0]  remainder;
   } div_sts_type;

   function automatic logic [CHAR_BITS-1:0] digit_to_char(input logic [BASE_BITS-1:0] d);
      logic [CHAR_BITS-1:0] c;
      if (d > NINE) begin
         c = CHAR_A + CHAR_BITS'(d - TEN);
      end else begin
         c = CHAR_ZERO + CHAR_BITS'(d);
      end
      return c;
   endfunction

endpackage

// ===== hdl/itrd_if.sv =====
// ----------------------------------------------------------------------------
// itrd_if
// Valid/ready channels carrying a value word and a digit word.
// ----------------------------------------------------------------------------
interface itrd_req_if;
   logic                            valid;
   logic                            ready;
   logic [itrd_pkg::VALUE_BITS-1:0] value;
   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface itrd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [itrd_pkg::CHAR_BITS-1:0] digit_char;
   logic                           last_digit;
   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// ===== hdl/integer_to_radix_digits_top.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits_top
// Converts a value word into ASCII digit words in a programmable base,
// most significant digit first, with the final digit flagged.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   value
//   rsp      out  valid/ready   digit_char, last_digit
//   csr      in   write enable  target base, 6 bits
//
// Each digit is produced by the bit-serial divider and written to the digit
// buffer; the digits are then emitted from the buffer, each passing through
// a read state and a load state.
// Reset is synchronous; the base returns to ten.
// A stalled rsp holds its word; the next value is taken while the final
// digit of the previous one still waits.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_top (
   input  logic                            clock,
   input  logic                            reset,
   itrd_req_if.sink                        req,
   itrd_rsp_if.source                      rsp,
   input  logic                            csr_write_enable,
   input  logic [itrd_pkg::BASE_BITS-1:0]  csr_write_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_LOAD = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [itrd_pkg::BASE_BITS-1:0]  base_ff;
   logic [itrd_pkg::BASE_BITS-1:0]  base_eff;
   logic [itrd_pkg::CNT_BITS-1:0]   n_ff, n_in;
   logic [itrd_pkg::IDX_BITS-1:0]   idx_ff, idx_in;
   logic [itrd_pkg::BASE_BITS-1:0]  buf_mem [itrd_pkg::VALUE_BITS];
   logic [itrd_pkg::BASE_BITS-1:0]  rd_data_ff;
   logic                            buf_we;
   logic                            out_valid_ff, out_valid_in;
   logic [itrd_pkg::CHAR_BITS-1:0]  out_char_ff, out_char_in;
   logic                            out_last_ff, out_last_in;
   logic                            out_free;
   itrd_pkg::div_ctl_type           div_ctl;
   itrd_pkg::div_sts_type           div_sts;

   itrd_divider u_divider (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .value (req.value),
      .base  (base_eff),
      .sts   (div_sts)
   );

   always_comb begin
      if (base_ff < itrd_pkg::BASE_MIN) begin
         base_eff = itrd_pkg::BASE_MIN;
      end else if (base_ff > itrd_pkg::BASE_MAX) begin
         base_eff = itrd_pkg::BASE_MAX;
      end else begin
         base_eff = base_ff;
      end
   end

   assign req.ready = state_ff == S_IDLE;
   assign out_free  = !out_valid_ff || rsp.ready;

   always_comb begin
      state_in          = state_ff;
      n_in              = n_ff;
      idx_in            = idx_ff;
      buf_we            = 1'b0;
      div_ctl.start     = 1'b0;
      div_ctl.use_input = 1'b0;
      out_valid_in      = out_valid_ff && !rsp.ready;
      out_char_in       = out_char_ff;
      out_last_in       = out_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               div_ctl.start     = 1'b1;
               div_ctl.use_input = 1'b1;
               n_in              = '0;
               state_in          = S_DIV;
            end
         end
         S_DIV: begin
            if (div_sts.done) begin
               buf_we = 1'b1;
               n_in   = n_ff + itrd_pkg::CNT_BITS'(1);
               if (div_sts.quotient_zero ||
                   n_in == itrd_pkg::CNT_BITS'(itrd_pkg::VALUE_BITS)) begin
                  idx_in   = n_ff[itrd_pkg::IDX_BITS-1:0];
                  state_in = S_READ;
               end else begin
                  div_ctl.start = 1'b1;
               end
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = itrd_pkg::digit_to_char(rd_data_ff);
               out_last_in  = idx_ff == '0;
               if (idx_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff - itrd_pkg::IDX_BITS'(1);
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= itrd_pkg::BASE_RESET;
         n_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            base_ff <= csr_write_data;
         end
      end
      idx_ff      <= idx_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   // digit buffer: one write, one registered read
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[n_ff[itrd_pkg::IDX_BITS-1:0]] <= div_sts.remainder;
      end
      rd_data_ff <= buf_mem[idx_ff];
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.digit_char = out_char_ff;
   assign rsp.last_digit = out_last_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> !div_sts.busy)
      else $error("divider restarted while busy");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV && div_sts.done |=> n_ff == $past(n_ff) + itrd_pkg::CNT_BITS'(1))
      else $error("digit count did not advance");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> div_sts.remainder < base_eff)
      else $error("digit not below the base");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp.ready |=> out_valid_ff)
      else $error("pending digit word dropped");

endmodule

// ===== hdl/itrd_divider.sv =====
// ----------------------------------------------------------------------------
// itrd_divider
// Bit-serial restoring divider: one quotient bit per cycle, remainder kept
// in a narrow register, quotient held for the next digit.
// ----------------------------------------------------------------------------
module itrd_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  itrd_pkg::div_ctl_type                ctl,
   input  logic [itrd_pkg::VALUE_BITS-1:0]      value,
   input  logic [itrd_pkg::BASE_BITS-1:0]       base,
   output itrd_pkg::div_sts_type                sts
);

   logic [itrd_pkg::VALUE_BITS-1:0] quo_ff, quo_in;
   logic [itrd_pkg::BASE_BITS-1:0]  rem_ff, rem_in;
   logic [itrd_pkg::IDX_BITS-1:0]   cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [itrd_pkg::BASE_BITS:0]    trial;
   logic                            fits;

   always_comb begin
      trial = {rem_ff, quo_ff[itrd_pkg::VALUE_BITS-1]};
      fits  = trial >= {1'b0, base};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         quo_in  = ctl.use_input ? value : quo_ff;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[itrd_pkg::VALUE_BITS-2:0], fits};
         rem_in = fits ? itrd_pkg::BASE_BITS'(trial - {1'b0, base})
                       : trial[itrd_pkg::BASE_BITS-1:0];
         cnt_in = cnt_ff + itrd_pkg::IDX_BITS'(1);
         if (cnt_ff == itrd_pkg::IDX_BITS'(itrd_pkg::VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign sts.busy          = busy_ff;
   assign sts.done          = done_ff;
   assign sts.quotient_zero = quo_ff == '0;
   assign sts.remainder     = rem_ff;

   a_rem_below_base: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !ctl.start |-> rem_ff < base)
      else $error("partial remainder reached the base");

endmodule

// ===== verif/integer_to_radix_digits_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_to_radix_digits_top_tb
// Drives value words into the radix digit converter under several bases,
// including out-of-range base settings that clamp to two and thirty-six.
// A table of directed values comes first, then random phases, each with a
// base of its own. Each digit word is checked against a digit string from the table
// or computed locally, with bursty input and a shifting stall pattern on the output.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_top_tb;

   localparam int RANDOM_ITEMS  = 450;
   localparam int SETTLE_CYCLES = 2 * (itrd_pkg::VALUE_BITS + 3);
   localparam int N_DIRECTED    = 21;
   localparam int ROW_BITS      = $clog2(N_DIRECTED);
   localparam logic [itrd_pkg::VALUE_BITS-1:0] VALUE_MAX = {itrd_pkg::VALUE_BITS{1'b1}};

   typedef struct packed {
      logic [itrd_pkg::CHAR_BITS-1:0] digit_char;
      logic                           last_digit;
   } digit_word_type;

   typedef struct packed {
      logic [itrd_pkg::BASE_BITS-1:0]  radix;
      logic [itrd_pkg::VALUE_BITS-1:0] value;
   } value_row_type;

   typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_BURSTY} rx_pattern_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_write_enable;
   logic [itrd_pkg::BASE_BITS-1:0] csr_write_data;

   itrd_req_if req_ch ();
   itrd_rsp_if rsp_ch ();

   integer_to_radix_digits_top dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   digit_word_type                 due_digits [$];
   digit_word_type                 head_digit;
   logic [itrd_pkg::BASE_BITS-1:0] radix_reg;
   int                             fail_count;
   int                             burst_left;
   rx_pattern_type                 ready_mode;
   int                             mode_left;
   int                             hold_left;

   // an empty string means: work the digits out from the current base
   value_row_type directed_rows [N_DIRECTED] = '{
      '{6'd10, 31'd0},
      '{6'd10, VALUE_MAX},
      '{6'd10, 31'd9},
      '{6'd10, 31'd10},
      '{6'd10, 31'd1234567},
      '{6'd2,  31'd0},
      '{6'd2,  31'd1},
      '{6'd2,  VALUE_MAX},
      '{6'd2,  31'h2AAAAAAA},
      '{6'd36, 31'd35},
      '{6'd36, 31'd36},
      '{6'd36, VALUE_MAX},
      '{6'd16, VALUE_MAX},
      '{6'd16, 31'h5A5A5A5A},
      '{6'd8,  VALUE_MAX},
      '{6'd3,  VALUE_MAX},
      '{6'd0,  31'd5},
      '{6'd1,  31'd6},
      '{6'd37, 31'd35},
      '{6'd63, 31'd36},
      '{6'd63, VALUE_MAX}
   };

   string directed_text [N_DIRECTED] = '{
      "0",
      "2147483647",
      "9",
      "10",
      "",
      "0",
      "1",
      "1111111111111111111111111111111",
      "",
      "Z",
      "10",
      "",
      "7FFFFFFF",
      "",
      "17777777777",
      "",
      "101",
      "110",
      "Z",
      "10",
      ""
   };

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void convert_value(input logic [itrd_pkg::VALUE_BITS-1:0] v);
      logic [itrd_pkg::BASE_BITS-1:0]  rems [itrd_pkg::VALUE_BITS];
      logic [itrd_pkg::VALUE_BITS-1:0] quotient;
      int unsigned                     b;
      int                              n;
      int                              k;
      digit_word_type                  w;
      if (radix_reg < itrd_pkg::BASE_MIN) begin
         b = 32'(itrd_pkg::BASE_MIN);
      end else if (radix_reg > itrd_pkg::BASE_MAX) begin
         b = 32'(itrd_pkg::BASE_MAX);
      end else begin
         b = 32'(radix_reg);
      end
      quotient = v;
      n = 0;
      do begin
         rems[n[itrd_pkg::IDX_BITS-1:0]] = itrd_pkg::BASE_BITS'(quotient % b);
         quotient = itrd_pkg::VALUE_BITS'(quotient / b);
         n++;
      end while (quotient != 0 && n < itrd_pkg::VALUE_BITS);
      for (k = n - 1; k >= 0; k--) begin
         if (rems[k[itrd_pkg::IDX_BITS-1:0]] > itrd_pkg::NINE) begin
            w.digit_char = itrd_pkg::CHAR_A +
               itrd_pkg::CHAR_BITS'(rems[k[itrd_pkg::IDX_BITS-1:0]] - itrd_pkg::TEN);
         end else begin
            w.digit_char = itrd_pkg::CHAR_ZERO +
               itrd_pkg::CHAR_BITS'(rems[k[itrd_pkg::IDX_BITS-1:0]]);
         end
         w.last_digit = (k == 0);
         due_digits.push_back(w);
      end
   endfunction

   task automatic set_radix(input logic [itrd_pkg::BASE_BITS-1:0] b);
      csr_write_enable <= 1'b1;
      csr_write_data   <= b;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      radix_reg = b;
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (due_digits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_value(input logic [itrd_pkg::VALUE_BITS-1:0] v, input string text);
      int             gap;
      int             i;
      digit_word_type w;
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         gap = $urandom_range(1, 16);
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.value <= v;
      do @(posedge clock); while (!req_ch.ready);
      if (text == "") begin
         convert_value(v);
      end else begin
         for (i = 0; i < text.len(); i++) begin
            w.digit_char = itrd_pkg::CHAR_BITS'(text[i]);
            w.last_digit = (i == text.len() - 1);
            due_digits.push_back(w);
         end
      end
   endtask

   // output side: check each accepted digit word, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (due_digits.size() == 0) begin
            $error("digit word with nothing due: digit_char %0d last_digit %0d",
                   rsp_ch.digit_char, rsp_ch.last_digit);
            fail_count++;
         end else begin
            head_digit = due_digits.pop_front();
            if (rsp_ch.digit_char !== head_digit.digit_char) begin
               $error("digit_char: expected %0d, got %0d",
                      head_digit.digit_char, rsp_ch.digit_char);
               fail_count++;
            end
            if (rsp_ch.last_digit !== head_digit.last_digit) begin
               $error("last_digit: expected %0d, got %0d",
                      head_digit.last_digit, rsp_ch.last_digit);
               fail_count++;
            end
         end
      end
      if (mode_left == 0) begin
         ready_mode = rx_pattern_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(16, 200);
      end else begin
         mode_left--;
      end
      case (ready_mode)
         RX_STEADY: rsp_ch.ready <= 1'b1;
         RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         default: begin
            if (hold_left != 0) begin
               rsp_ch.ready <= 1'b0;
               hold_left--;
            end else begin
               rsp_ch.ready <= 1'b1;
               if ($urandom_range(0, 5) == 0) hold_left = $urandom_range(1, 12);
            end
         end
      endcase
   end

   initial begin
      #60_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int                              i;
      int                              sent;
      int                              phase_len;
      logic [itrd_pkg::BASE_BITS-1:0]  pick_radix;
      logic [itrd_pkg::VALUE_BITS-1:0] pick_value;
      fail_count = 0;
      burst_left = 0;
      mode_left  = 0;
      hold_left  = 0;
      ready_mode = RX_STEADY;
      radix_reg  = itrd_pkg::BASE_RESET;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.value     <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < N_DIRECTED; i++) begin
         if (directed_rows[i[ROW_BITS-1:0]].radix != radix_reg) begin
            settle();
            set_radix(directed_rows[i[ROW_BITS-1:0]].radix);
         end
         send_value(directed_rows[i[ROW_BITS-1:0]].value, directed_text[i[ROW_BITS-1:0]]);
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         settle();
         case ($urandom_range(0, 9))
            0:       pick_radix = itrd_pkg::BASE_MIN;
            1:       pick_radix = itrd_pkg::BASE_MAX;
            2:       pick_radix = itrd_pkg::BASE_BITS'($urandom_range(0, 1));
            3:       pick_radix = itrd_pkg::BASE_BITS'($urandom_range(37, 63));
            default: pick_radix = itrd_pkg::BASE_BITS'($urandom_range(3, 35));
         endcase
         set_radix(pick_radix);
         phase_len = $urandom_range(8, 40);
         repeat (phase_len) begin
            case ($urandom_range(0, 9))
               0:       pick_value = '0;
               1:       pick_value = VALUE_MAX;
               2:       pick_value = itrd_pkg::VALUE_BITS'($urandom_range(0, 255));
               3, 4:    pick_value = itrd_pkg::VALUE_BITS'($urandom_range(0, 65535));
               default: pick_value = itrd_pkg::VALUE_BITS'($urandom);
            endcase
            send_value(pick_value, "");
            sent++;
            if ($urandom_range(0, 49) == 0) settle();
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
